// File: design/fnvds_pkg.sv
// Shared constants, payload types and hash helpers for the FNV-1a seen-set block.
package fnvds_pkg;

    // Table size; must be a power of two so the probe wraps by truncation.
    localparam int TABLE_SLOTS = 256;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int HASH_W      = 64;

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
    // FNV prime is 2^40 + 2^8 + 0xb3; multiply as shifts plus a byte product.
    localparam logic [7:0] MUL_TAIL = 8'hb3;

    localparam logic [1:0] OUTCOME_NEW  = 2'd0;
    localparam logic [1:0] OUTCOME_SEEN = 2'd1;
    localparam logic [1:0] OUTCOME_FULL = 2'd2;

    typedef struct packed {
        logic [7:0]  kind;
        logic [15:0] code_unit;
        logic        has_unit;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        outcome;
        logic [HASH_W-1:0] name_hash;
        logic [7:0]        slot_index;
    } out_item_t;

    // One FNV-1a step: xor in a byte, multiply by the prime modulo 2^64.
    function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
        logic [HASH_W-1:0] x;
        logic [HASH_W-1:0] tail;
        x    = h ^ {{(HASH_W-8){1'b0}}, b};
        tail = x * {{(HASH_W-8){1'b0}}, MUL_TAIL};
        return (x << 40) + (x << 8) + tail;
    endfunction

    // Start slot: low word xor high word, reduced to the table size.
    function automatic logic [SLOT_W-1:0] start_slot(input logic [HASH_W-1:0] h);
        logic [31:0] folded;
        folded = h[31:0] ^ h[63:32];
        return folded[SLOT_W-1:0];
    endfunction

endpackage

// File: design/fnv1a_dedup_seen_set.sv
// FNV-1a name hasher with a linear-probing seen-set held in one synchronous memory.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  s_      | in        | s_valid / s_ready  | fnvds_pkg::in_item_t  (kind, unit, flags)
//  m_      | out       | m_valid / m_ready  | fnvds_pkg::out_item_t (outcome, hash, slot)
//
// Steps: a name item is accepted in the idle state, then the kind byte is folded on the
//   first item of a name, then the two unit bytes if present (one FNV step per cycle).
// A last item adds a finishing step, a memory read then a compare and write back per
//   probed slot, and a load of the output register; the probe walk sets the tail cost.
// Reset clears the per-slot valid flops at once; no clearing pass is needed.
// The output register holds a finished result while the next name streams in; a new
//   result waits on m_ready to load, and no input is taken while it waits.
module fnv1a_dedup_seen_set (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  fnvds_pkg::in_item_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output fnvds_pkg::out_item_t  m_data
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_KIND = 7'b0000010,
        ST_LO   = 7'b0000100,
        ST_HI   = 7'b0001000,
        ST_FIN  = 7'b0010000,
        ST_READ = 7'b0100000,
        ST_CMP  = 7'b1000000
    } state_t;

    // Emit is folded into the compare step via a pending flag below.
    state_t state_reg, state_next;

    fnvds_pkg::in_item_t               item_reg, item_next;
    logic [fnvds_pkg::HASH_W-1:0]      hash_reg, hash_next;
    logic                              mid_name_reg, mid_name_next;
    logic [fnvds_pkg::HASH_W-1:0]      probe_hash_reg, probe_hash_next;
    logic [fnvds_pkg::SLOT_W-1:0]      slot_reg, slot_next;
    logic [fnvds_pkg::SLOT_W-1:0]      count_reg, count_next;
    logic                              pend_reg, pend_next;
    logic [1:0]                        outcome_reg, outcome_next;
    logic                              m_valid_reg, m_valid_next;
    fnvds_pkg::out_item_t              m_data_reg, m_data_next;

    // Seen table: hashes in memory, occupancy in flops cleared by reset.
    logic [fnvds_pkg::HASH_W-1:0]      seen_mem [fnvds_pkg::TABLE_SLOTS];
    logic [fnvds_pkg::TABLE_SLOTS-1:0] valid_reg;
    logic [fnvds_pkg::HASH_W-1:0]      rd_data_reg;
    logic                              vld_rd_reg;
    logic                              mem_we;
    logic [fnvds_pkg::HASH_W-1:0]      fixed_hash;
    logic                              emit_go;

    // A result is pending until it moves into the output register.
    assign emit_go = pend_reg && (!m_valid_reg || m_ready);
    assign s_ready = (state_reg == ST_IDLE) && !pend_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A zero hash is reserved for empty slots; substitute 1.
    assign fixed_hash = (hash_reg == '0) ? {{(fnvds_pkg::HASH_W-1){1'b0}}, 1'b1} : hash_reg;

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        hash_next       = hash_reg;
        mid_name_next   = mid_name_reg;
        probe_hash_next = probe_hash_reg;
        slot_next       = slot_reg;
        count_next      = count_reg;
        pend_next       = pend_reg;
        outcome_next    = outcome_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;

        // Drain a pending result into the output register when it frees up.
        if (emit_go) begin
            pend_next              = 1'b0;
            m_valid_next           = 1'b1;
            m_data_next.outcome    = outcome_reg;
            m_data_next.name_hash  = probe_hash_reg;
            m_data_next.slot_index = 8'(slot_reg);
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    item_next     = s_data;
                    mid_name_next = !s_data.last;
                    // First item of a name seeds the hash with the kind byte.
                    if (!mid_name_reg) begin
                        state_next = ST_KIND;
                    end else if (s_data.has_unit) begin
                        state_next = ST_LO;
                    end else if (s_data.last) begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_KIND: begin
                hash_next = fnvds_pkg::fnv_fold(fnvds_pkg::FNV_BASIS, item_reg.kind);
                if (item_reg.has_unit) begin
                    state_next = ST_LO;
                end else if (item_reg.last) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_LO: begin
                hash_next  = fnvds_pkg::fnv_fold(hash_reg, item_reg.code_unit[7:0]);
                state_next = ST_HI;
            end
            ST_HI: begin
                hash_next  = fnvds_pkg::fnv_fold(hash_reg, item_reg.code_unit[15:8]);
                state_next = item_reg.last ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                // Hold the finished hash for the probe and restart the running hash.
                probe_hash_next = fixed_hash;
                slot_next       = fnvds_pkg::start_slot(fixed_hash);
                count_next      = '0;
                hash_next       = fnvds_pkg::FNV_BASIS;
                state_next      = ST_READ;
            end
            ST_READ: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                // Test for a match before emptiness, as the set semantics require.
                if (vld_rd_reg && (rd_data_reg == probe_hash_reg)) begin
                    outcome_next = fnvds_pkg::OUTCOME_SEEN;
                    pend_next    = 1'b1;
                    state_next   = ST_IDLE;
                end else if (!vld_rd_reg) begin
                    mem_we       = 1'b1;
                    outcome_next = fnvds_pkg::OUTCOME_NEW;
                    pend_next    = 1'b1;
                    state_next   = ST_IDLE;
                end else if (count_reg == fnvds_pkg::SLOT_W'(fnvds_pkg::TABLE_SLOTS - 1)) begin
                    outcome_next = fnvds_pkg::OUTCOME_FULL;
                    slot_next    = '0;
                    pend_next    = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    // Advance to the next slot; wrap comes free with a power-of-two table.
                    slot_next  = slot_reg + fnvds_pkg::SLOT_W'(1);
                    count_next = count_reg + fnvds_pkg::SLOT_W'(1);
                    state_next = ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            hash_reg     <= fnvds_pkg::FNV_BASIS;
            mid_name_reg <= 1'b0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            hash_reg     <= hash_next;
            mid_name_reg <= mid_name_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        probe_hash_reg <= probe_hash_next;
        slot_reg       <= slot_next;
        count_reg      <= count_next;
        outcome_reg    <= outcome_next;
        m_data_reg     <= m_data_next;
    end

    // Occupancy flops: reset empties the whole table at once.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (mem_we) begin
            valid_reg[slot_reg] <= 1'b1;
        end
    end

    // Memory port: registered read in the read step, write back on insert.
    // Reads and writes of a slot fall in different steps, so no forwarding is needed.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            rd_data_reg <= seen_mem[slot_reg];
            vld_rd_reg  <= valid_reg[slot_reg];
        end
        if (mem_we) begin
            seen_mem[slot_reg] <= probe_hash_reg;
        end
    end

    // Insert only into a slot that was read as empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> !vld_rd_reg)
        else $error("insert into occupied slot");

    // An insert marks its slot occupied.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> valid_reg[$past(slot_reg)])
        else $error("inserted slot not marked valid");

    // Emitted hashes are never the empty marker.
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit_go |=> (m_valid_reg && (m_data_reg.name_hash != '0)))
        else $error("zero hash emitted");

    // A full table reports slot zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.outcome == fnvds_pkg::OUTCOME_FULL))
            |-> (m_data_reg.slot_index == '0))
        else $error("full outcome with nonzero slot");

endmodule
